[hw/rtl/jsfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types and constants of the JSON string field extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

  localparam logic [7:0]  QUOTE_CH   = 8'h22;
  localparam logic [7:0]  BSLASH_CH  = 8'h5C;

  // Key bytes held in the configuration registers.
  localparam int          KEY_BYTES  = 32;
  localparam int          CFG_DATA_W = 64;
  localparam int          CFG_IDX_W  = 3;
  localparam int          KEY_LEN_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_8  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_16 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_24 = 3'd4;

  localparam logic        STATUS_OK  = 1'b0;
  localparam logic        STATUS_ERR = 1'b1;

  localparam logic [15:0] LEN_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  value_byte;
    logic        value_byte_valid;
    logic        finished;
    logic        result_status;
    logic [15:0] value_length;
  } out_item_t;

endpackage

[hw/rtl/jsfe_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_window
// Window of recent text bytes and parallel compare against '"' key '"'.
// ----------------------------------------------------------------------------
module jsfe_window #(
  parameter int KEY_MAX = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                shift_en,
  input  logic                                clear,
  input  logic [7:0]                          text_byte,
  input  logic [jsfe_pkg::KEY_LEN_W-1:0]      key_length,
  input  logic [jsfe_pkg::KEY_BYTES*8-1:0]    key_bytes,
  output logic                                match_nxt
);

  localparam int WIN_LEN = KEY_MAX + 2;
  localparam int LEN_W   = $clog2(KEY_MAX + 1);

  logic [7:0]       win_r [WIN_LEN];
  logic [7:0]       win_nxt [WIN_LEN];
  logic [LEN_W-1:0] len_eff;
  logic             close_ok;
  logic             key_ok;

  function automatic logic [7:0] key_sel(input logic [LEN_W-1:0] k,
                                         input logic [jsfe_pkg::KEY_BYTES*8-1:0] kv);
    logic [7:0] sel;
    sel = 8'h00;
    for (int m = 0; m < jsfe_pkg::KEY_BYTES; m++) begin
      if (32'(k) == m) begin
        sel = kv[8*m +: 8];
      end
    end
    return sel;
  endfunction

  always_comb begin
    if (7'(key_length) > 7'(KEY_MAX)) begin
      len_eff = LEN_W'(KEY_MAX);
    end else begin
      len_eff = LEN_W'(key_length);
    end
  end

  // Newest byte sits at index 0.
  always_comb begin
    win_nxt[0] = text_byte;
    for (int j = 1; j < WIN_LEN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  always_comb begin
    close_ok = 1'b0;
    for (int j = 0; j <= KEY_MAX; j++) begin
      if (32'(len_eff) == j) begin
        close_ok = (win_nxt[j+1] == jsfe_pkg::QUOTE_CH);
      end
    end
    key_ok = 1'b1;
    for (int i = 1; i <= KEY_MAX; i++) begin
      if (32'(len_eff) >= i) begin
        // Oldest key byte lands deepest in the window.
        if (win_nxt[i] != key_sel(len_eff - LEN_W'(i), key_bytes)) begin
          key_ok = 1'b0;
        end
      end
    end
    match_nxt = (win_nxt[0] == jsfe_pkg::QUOTE_CH) && close_ok && key_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int j = 0; j < WIN_LEN; j++) begin
        win_r[j] <= 8'h00;
      end
    end else if (shift_en) begin
      for (int j = 0; j < WIN_LEN; j++) begin
        win_r[j] <= win_nxt[j];
      end
    end
  end

endmodule

[hw/rtl/jsfe_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_out_buf
// Result register with a skid stage; absorbs a result while the output stalls.
// ----------------------------------------------------------------------------
module jsfe_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jsfe_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output jsfe_pkg::out_item_t out_data
);

  logic                out_valid_r;
  logic                skid_valid_r;
  jsfe_pkg::out_item_t out_data_r;
  jsfe_pkg::out_item_t skid_r;
  logic                pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // Input is held off while the skid stage is occupied.
      if (pop) begin
        out_data_r   <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= push_item;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= push_item;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

[hw/rtl/json_string_field_extractor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_field_extractor_top
// Extracts the raw string value of a configured key from a JSON byte stream.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle unless in_stall is high and answers
// each item with at most one result, held in the result register or skid stage.
// The key match is a parallel compare of the byte window against the quoted
// key, so an item can enter every cycle; in_stall rises only when both the
// result register and its skid stage hold results that the output side has
// not yet taken. Configure key_length and the key byte registers while idle;
// there is no clearing pass after reset.
module json_string_field_extractor_top #(
  parameter int KEY_MAX = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  jsfe_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output jsfe_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [jsfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jsfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_OPEN,
    PH_VALUE,
    PH_DONE
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                bs_r, bs_nxt;
  logic [15:0]         len_r, len_nxt;
  logic [jsfe_pkg::KEY_LEN_W-1:0]  key_length_r;
  logic [jsfe_pkg::CFG_DATA_W-1:0] key_r [4];
  logic [jsfe_pkg::KEY_BYTES*8-1:0] key_bytes;
  logic                in_fire;
  logic                buf_full;
  logic                shift_en;
  logic                win_clear;
  logic                match_nxt;
  logic                res_push;
  jsfe_pkg::out_item_t res_item;

  assign in_stall  = buf_full;
  assign in_fire   = in_valid && !buf_full;
  assign key_bytes = {key_r[3], key_r[2], key_r[1], key_r[0]};
  assign shift_en  = in_fire && !in_data.end_of_text && (phase_r == PH_SEARCH);
  assign win_clear = in_fire && in_data.end_of_text;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= 6'd1;
      for (int r = 0; r < 4; r++) begin
        key_r[r] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        jsfe_pkg::REG_KEY_LENGTH:   key_length_r <= cfg_data[jsfe_pkg::KEY_LEN_W-1:0];
        jsfe_pkg::REG_KEY_BYTES_0:  key_r[0] <= cfg_data;
        jsfe_pkg::REG_KEY_BYTES_8:  key_r[1] <= cfg_data;
        jsfe_pkg::REG_KEY_BYTES_16: key_r[2] <= cfg_data;
        jsfe_pkg::REG_KEY_BYTES_24: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  jsfe_window #(
    .KEY_MAX(KEY_MAX)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (shift_en),
    .clear      (win_clear),
    .text_byte  (in_data.text_byte),
    .key_length (key_length_r),
    .key_bytes  (key_bytes),
    .match_nxt  (match_nxt)
  );

  always_comb begin
    phase_nxt = phase_r;
    bs_nxt    = bs_r;
    len_nxt   = len_r;
    res_push  = 1'b0;
    res_item  = '0;
    if (in_fire) begin
      priority if (in_data.end_of_text) begin
        // Terminator re-arms; report an error unless the value already closed.
        if (phase_r != PH_DONE) begin
          res_push               = 1'b1;
          res_item.finished      = 1'b1;
          res_item.result_status = jsfe_pkg::STATUS_ERR;
        end
        phase_nxt = PH_SEARCH;
        bs_nxt    = 1'b0;
        len_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_SEARCH: begin
            if (match_nxt) begin
              phase_nxt = PH_OPEN;
            end
          end
          PH_OPEN: begin
            if (in_data.text_byte == jsfe_pkg::QUOTE_CH) begin
              phase_nxt = PH_VALUE;
              bs_nxt    = 1'b0;
              len_nxt   = '0;
            end
          end
          PH_VALUE: begin
            res_push = 1'b1;
            if (in_data.text_byte == jsfe_pkg::QUOTE_CH && !bs_r) begin
              phase_nxt              = PH_DONE;
              res_item.finished      = 1'b1;
              res_item.result_status = jsfe_pkg::STATUS_OK;
              res_item.value_length  = len_r;
            end else begin
              if (len_r != jsfe_pkg::LEN_MAX) begin
                len_nxt = len_r + 16'd1;
              end
              bs_nxt                    = (in_data.text_byte == jsfe_pkg::BSLASH_CH);
              res_item.value_byte       = in_data.text_byte;
              res_item.value_byte_valid = 1'b1;
            end
          end
          PH_DONE: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      bs_r    <= 1'b0;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      bs_r    <= bs_nxt;
      len_r   <= len_nxt;
    end
  end

  jsfe_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[bench/json_string_field_extractor_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_field_extractor_top_tb
// Self-checking bench for the JSON string field extractor.
// ----------------------------------------------------------------------------
// Streams JSON-like texts into the block one byte per item and checks every
// result against a local scanner that tracks the key window, the value copy,
// the escape rule and the saturating length. Directed texts come first, then
// random texts under a range of keys and a long output hold-off that fills
// the block.
module json_string_field_extractor_top_tb;

  localparam int WIN_BYTES     = jsfe_pkg::KEY_BYTES + 2;
  localparam int RANDOM_ITEMS  = 1570;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int MAX_REPORTS   = 40;
  localparam int HOLD_CYCLES   = 300;

  typedef enum logic [1:0] {FIND_KEY, FIND_OPEN, COPY_VALUE, CLOSED} scan_phase_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  jsfe_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  jsfe_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [jsfe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [jsfe_pkg::CFG_DATA_W-1:0] cfg_data;

  // scanner state and its copy of the key registers
  scan_phase_t                     scan_phase;
  logic [7:0]                      recent_window [0:WIN_BYTES-1];
  logic                            after_backslash;
  logic [15:0]                     value_count;
  logic [jsfe_pkg::KEY_LEN_W-1:0]  key_len_reg;
  logic [jsfe_pkg::CFG_DATA_W-1:0] key_word_reg [0:3];

  jsfe_pkg::out_item_t             expected_results [$];
  int                              mismatch_count = 0;
  int                              cycle_count;

  // stimulus side
  jsfe_pkg::in_item_t              text_q [$];
  logic [7:0]                      key_text [0:jsfe_pkg::KEY_BYTES-1];
  int                              key_span;
  bit                              tx_gaps_on = 1'b1;
  bit                              rx_gaps_on = 1'b1;
  int                              rx_hold_req = 0;

  json_string_field_extractor_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scanner
  // --------------------------------------------------------------------------
  function automatic void clear_scan();
    foreach (recent_window[i]) recent_window[i] = 8'h00;
    scan_phase      = FIND_KEY;
    after_backslash = 1'b0;
    value_count     = 16'd0;
  endfunction

  function automatic logic [7:0] key_reg_byte(input int k);
    return key_word_reg[k / 8][8 * (k % 8) +: 8];
  endfunction

  // window holds the newest byte at index 0, so the key reads backwards
  function automatic bit quoted_key_in_window();
    int len;
    bit hit;
    len = (key_len_reg > jsfe_pkg::KEY_BYTES) ? jsfe_pkg::KEY_BYTES : int'(key_len_reg);
    hit = (recent_window[0] == jsfe_pkg::QUOTE_CH) &&
          (recent_window[len + 1] == jsfe_pkg::QUOTE_CH);
    for (int i = 1; i <= len; i++) begin
      if (recent_window[i] != key_reg_byte(len - i)) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic bit predict_extraction(input jsfe_pkg::in_item_t item,
                                            output jsfe_pkg::out_item_t res);
    bit produced;
    res      = '0;
    produced = 1'b0;
    if (item.end_of_text) begin
      if (scan_phase != CLOSED) begin
        res.finished      = 1'b1;
        res.result_status = jsfe_pkg::STATUS_ERR;
        produced          = 1'b1;
      end
      clear_scan();
    end else begin
      unique case (scan_phase)
        FIND_KEY: begin
          for (int i = WIN_BYTES - 1; i > 0; i--) recent_window[i] = recent_window[i - 1];
          recent_window[0] = item.text_byte;
          if (quoted_key_in_window()) scan_phase = FIND_OPEN;
        end
        FIND_OPEN: begin
          if (item.text_byte == jsfe_pkg::QUOTE_CH) begin
            scan_phase      = COPY_VALUE;
            after_backslash = 1'b0;
            value_count     = 16'd0;
          end
        end
        COPY_VALUE: begin
          if (item.text_byte == jsfe_pkg::QUOTE_CH && !after_backslash) begin
            scan_phase        = CLOSED;
            res.finished      = 1'b1;
            res.result_status = jsfe_pkg::STATUS_OK;
            res.value_length  = value_count;
          end else begin
            if (value_count != jsfe_pkg::LEN_MAX) value_count++;
            after_backslash      = (item.text_byte == jsfe_pkg::BSLASH_CH);
            res.value_byte       = item.text_byte;
            res.value_byte_valid = 1'b1;
          end
          produced = 1'b1;
        end
        default: begin
        end
      endcase
    end
    return produced;
  endfunction

  function automatic void apply_cfg(input logic [jsfe_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [jsfe_pkg::CFG_DATA_W-1:0] data);
    unique case (idx)
      jsfe_pkg::REG_KEY_LENGTH:   key_len_reg     = data[jsfe_pkg::KEY_LEN_W-1:0];
      jsfe_pkg::REG_KEY_BYTES_0:  key_word_reg[0] = data;
      jsfe_pkg::REG_KEY_BYTES_8:  key_word_reg[1] = data;
      jsfe_pkg::REG_KEY_BYTES_16: key_word_reg[2] = data;
      jsfe_pkg::REG_KEY_BYTES_24: key_word_reg[3] = data;
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  task automatic check_result(input jsfe_pkg::out_item_t got);
    jsfe_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: %h", got));
    end else begin
      want = expected_results.pop_front();
      if (got.value_byte !== want.value_byte)
        report_mismatch($sformatf("value_byte %h, want %h", got.value_byte, want.value_byte));
      if (got.value_byte_valid !== want.value_byte_valid)
        report_mismatch($sformatf("value_byte_valid %b, want %b",
                                  got.value_byte_valid, want.value_byte_valid));
      if (got.finished !== want.finished)
        report_mismatch($sformatf("finished %b, want %b", got.finished, want.finished));
      if (got.result_status !== want.result_status)
        report_mismatch($sformatf("result_status %b, want %b",
                                  got.result_status, want.result_status));
      if (got.value_length !== want.value_length)
        report_mismatch($sformatf("value_length %0d, want %0d",
                                  got.value_length, want.value_length));
    end
  endtask

  always @(posedge clk) begin : monitor
    jsfe_pkg::out_item_t res;
    if (!rst_n) begin
      key_len_reg = jsfe_pkg::KEY_LEN_W'(1);
      foreach (key_word_reg[i]) key_word_reg[i] = '0;
      clear_scan();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) begin
        if (predict_extraction(in_data, res)) expected_results.push_back(res);
      end
      if (cfg_we) apply_cfg(cfg_index, cfg_data);
    end
  end

  // --------------------------------------------------------------------------
  // Result side: a random stall before each item, or a long hold on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        n           = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        n = rx_gaps_on ? $urandom_range(0, 16) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count,
             expected_results.size());
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_item(input jsfe_pkg::in_item_t item);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i]);
    text_q.delete();
  endtask

  function automatic void put_byte(input logic [7:0] b);
    jsfe_pkg::in_item_t it;
    it.text_byte   = b;
    it.end_of_text = 1'b0;
    text_q.push_back(it);
  endfunction

  // the byte on a terminator is ignored, so randomize it
  function automatic void put_term();
    jsfe_pkg::in_item_t it;
    it.text_byte   = 8'($urandom);
    it.end_of_text = 1'b1;
    text_q.push_back(it);
  endfunction

  function automatic logic [7:0] other_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == jsfe_pkg::QUOTE_CH) b = 8'h20;
    return b;
  endfunction

  function automatic void put_quoted_key();
    put_byte(jsfe_pkg::QUOTE_CH);
    for (int k = 0; k < key_span; k++) put_byte(key_text[k]);
    put_byte(jsfe_pkg::QUOTE_CH);
  endfunction

  // near miss: the key with one bit flipped, or one non-quote byte for an empty key
  function automatic void put_decoy();
    int flip;
    logic [7:0] b;
    put_byte(jsfe_pkg::QUOTE_CH);
    if (key_span == 0) begin
      put_byte(other_byte());
    end else begin
      flip = $urandom_range(0, key_span - 1);
      for (int k = 0; k < key_span; k++) begin
        b = key_text[k];
        if (k == flip) b ^= 8'(1 << $urandom_range(0, 7));
        put_byte(b);
      end
    end
    put_byte(jsfe_pkg::QUOTE_CH);
  endfunction

  // let the last accepted item reach the scanner before looking at the queue
  task automatic drain_idle();
    int waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_key(input logic [jsfe_pkg::KEY_LEN_W-1:0] len,
                             input logic [jsfe_pkg::CFG_DATA_W-1:0] w0, w1, w2, w3);
    logic [jsfe_pkg::CFG_DATA_W-1:0] words [0:3];
    logic [jsfe_pkg::CFG_IDX_W-1:0]  word_regs [0:3];
    logic [jsfe_pkg::CFG_DATA_W-1:0] len_word;
    words     = '{w0, w1, w2, w3};
    word_regs = '{jsfe_pkg::REG_KEY_BYTES_0, jsfe_pkg::REG_KEY_BYTES_8,
                  jsfe_pkg::REG_KEY_BYTES_16, jsfe_pkg::REG_KEY_BYTES_24};
    drain_idle();
    // junk in the upper bits must be dropped
    len_word                          = {$urandom, $urandom};
    len_word[jsfe_pkg::KEY_LEN_W-1:0] = len;
    cfg_we    <= 1'b1;
    cfg_index <= jsfe_pkg::REG_KEY_LENGTH;
    cfg_data  <= len_word;
    @(posedge clk);
    for (int r = 0; r < 4; r++) begin
      cfg_index <= word_regs[r];
      cfg_data  <= words[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    for (int k = 0; k < jsfe_pkg::KEY_BYTES; k++) key_text[k] = words[k / 8][8 * (k % 8) +: 8];
    key_span = (len > jsfe_pkg::KEY_BYTES) ? jsfe_pkg::KEY_BYTES : int'(len);
  endtask

  task automatic build_random_text(output int counted);
    int kind;
    int n;
    int pick;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // noise, quote-heavy so partial matches show up
      n = $urandom_range(1, 24);
      repeat (n) put_byte(($urandom_range(0, 3) == 0) ? jsfe_pkg::QUOTE_CH : 8'($urandom));
      put_term();
      counted = text_q.size();
    end else begin
      put_byte(8'h7B);
      repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
      if ($urandom_range(0, 2) == 0) put_decoy();
      // kind 1 drops the key, kind 2 the opening quote, kind 3 the close
      if (kind != 1) put_quoted_key();
      repeat ($urandom_range(0, 2)) put_byte(other_byte());
      if (kind != 1 && kind != 2) begin
        put_byte(jsfe_pkg::QUOTE_CH);
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(0, 7);
          unique case (pick)
            0: begin
              put_byte(jsfe_pkg::BSLASH_CH);
              put_byte(jsfe_pkg::QUOTE_CH);
            end
            1: begin
              put_byte(jsfe_pkg::BSLASH_CH);
              put_byte(jsfe_pkg::BSLASH_CH);
            end
            default: put_byte(other_byte());
          endcase
        end
        if (kind != 3) put_byte(jsfe_pkg::QUOTE_CH);
      end
      repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
      put_term();
      counted = text_q.size();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset key is one zero byte; escaped quote, 0xFF and a close then two terminators
  task automatic test_reset_key();
    put_byte(jsfe_pkg::QUOTE_CH);
    put_byte(8'h00);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_byte(8'hFF);
    put_byte(jsfe_pkg::BSLASH_CH);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_byte(8'h61);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_term();
    put_term();
    send_text();
  endtask

  // empty key: two adjacent quotes match; an escaped backslash still escapes
  task automatic test_empty_key();
    program_key('0, '1, '1, '1, '1);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_byte(jsfe_pkg::BSLASH_CH);
    put_byte(jsfe_pkg::BSLASH_CH);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_byte(8'h00);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_term();
    send_text();
  endtask

  // terminator while searching, while seeking the opening quote, inside value
  task automatic test_format_errors();
    program_key(jsfe_pkg::KEY_LEN_W'(1), 64'h6B, '0, '0, '0);
    put_term();
    put_quoted_key();
    put_term();
    put_quoted_key();
    put_byte(8'h3A);
    put_byte(jsfe_pkg::QUOTE_CH);
    put_byte(8'h41);
    put_term();
    send_text();
  endtask

  task automatic test_random_texts();
    int sent;
    int setting;
    int counted;
    int len;
    sent    = 0;
    setting = 0;
    while (sent < RANDOM_ITEMS) begin
      case (setting)
        0: program_key(jsfe_pkg::KEY_LEN_W'(jsfe_pkg::KEY_BYTES), '1, '1, '1, '1);
        1: program_key('1, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
        2: program_key('0, {$urandom, $urandom}, '0, '0, '0);
        3: program_key(jsfe_pkg::KEY_LEN_W'(1), '0, '0, '0, '0);
        default: begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8);
          program_key(jsfe_pkg::KEY_LEN_W'(len), {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        end
      endcase
      for (int t = 0; t < 12 && sent < RANDOM_ITEMS; t++) begin
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_gaps_on = ($urandom_range(0, 3) != 0);
        build_random_text(counted);
        sent += counted;
        send_text();
      end
      setting++;
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // hold the output off while the input keeps offering value bytes
  task automatic test_backpressure();
    program_key(jsfe_pkg::KEY_LEN_W'(1), 64'h6B, '0, '0, '0);
    tx_gaps_on  = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    put_quoted_key();
    put_byte(8'h3A);
    put_byte(jsfe_pkg::QUOTE_CH);
    repeat (40) put_byte(other_byte());
    put_byte(jsfe_pkg::QUOTE_CH);
    put_term();
    send_text();
    drain_idle();
    tx_gaps_on = 1'b1;
  endtask

  initial begin : main
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    key_span  = 1;
    foreach (key_text[k]) key_text[k] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_empty_key();
    test_format_errors();
    test_random_texts();
    test_backpressure();

    drain_idle();
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
